// File: src/rv32im_instruction_execute_core_assert.svh
// Assertion macros for the execute core.
`ifndef RV32IM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define RV32IM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RVX_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define RVX_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: src/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Operation codes, status codes and shared types of the execute core.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;
  localparam logic [5:0] OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_ADDI = 6'd2, OP_SLTI = 6'd3,
    OP_SLTIU = 6'd4, OP_XORI = 6'd5, OP_ORI = 6'd6, OP_ANDI = 6'd7, OP_SLLI = 6'd8,
    OP_SRLI = 6'd9, OP_SRAI = 6'd10, OP_ADD = 6'd11, OP_SUB = 6'd12, OP_SLT = 6'd13,
    OP_SLTU = 6'd14, OP_XOR = 6'd15, OP_OR = 6'd16, OP_AND = 6'd17, OP_SRL = 6'd18,
    OP_SRA = 6'd19, OP_ECALL = 6'd20, OP_EBREAK = 6'd21, OP_LB = 6'd22, OP_LH = 6'd23,
    OP_LW = 6'd24, OP_LBU = 6'd25, OP_LHU = 6'd26, OP_SB = 6'd27, OP_SH = 6'd28,
    OP_SW = 6'd29, OP_JAL = 6'd30, OP_JALR = 6'd31, OP_BEQ = 6'd32, OP_BNE = 6'd33,
    OP_BLT = 6'd34, OP_BGE = 6'd35, OP_BLTU = 6'd36, OP_BGEU = 6'd37, OP_MUL = 6'd38,
    OP_MULH = 6'd39, OP_MULHSU = 6'd40, OP_MULHU = 6'd41, OP_DIV = 6'd42,
    OP_DIVU = 6'd43, OP_REM = 6'd44, OP_REMU = 6'd45;
  localparam logic [2:0] ST_OK = 3'd0, ST_ECALL = 3'd1, ST_EBREAK = 3'd2, ST_EXIT = 3'd3,
    ST_NEG = 3'd4;
  // Divider control between the top level and the divide unit.
  typedef struct packed {
    logic        start;
    logic        signed_op;
    logic        want_rem;
  } div_ctl_t;
  typedef struct packed {
    logic        busy;
    logic        done;
  } div_sts_t;
endpackage
`default_nettype wire

// File: src/rv32im_instruction_execute_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_instruction_execute_core
// Multicycle RV32IM execute core with register file, PC and data memory.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    cmd, first_reg, second_reg, operand_value
// out_     output     out_valid/out_ready  status, next_pc, dest_written, dest_value
//
// An ALU instruction passes through accept, register reads, execute, write back
// and the result transfer before the next input transfer. Branches add a second
// ALU pass that forms the target. Stores go one byte per cycle through the
// single byte-wide memory port; loads spend a memory state and a wait state per
// byte on the registered read. Divide and remainder add a wait on the radix-2
// divider. Reset clears the register file and PC; the memory has no reset. A
// result waits in the output register while out_ready is low, and no new
// instruction is accepted until it is taken.
module rv32im_instruction_execute_core #(
  parameter int DMEM_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  in_cmd,
  input  wire logic [4:0]  in_first_reg,
  input  wire logic [4:0]  in_second_reg,
  input  wire logic signed [31:0] in_operand_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [31:0]      out_next_pc,
  output logic             out_dest_written,
  output logic [31:0]      out_dest_value
);
  import rvx_pkg::*;
  `include "rv32im_instruction_execute_core_assert.svh"

  localparam int AW = $clog2(DMEM_BYTES);
  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_EXEC = 4'd2, S_BR = 4'd3,
    S_MEM = 4'd4, S_MWAIT = 4'd5, S_DIV = 4'd6, S_DONE = 4'd7, S_OUT = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  cmd_r;
  logic [4:0]  rd_r, rs_r;
  logic [31:0] v_r, a_r, b_r, d_r, pc_r, pc_nxt, imm, acc_r, addr_r;
  logic [31:0] regs_r [32];
  logic [7:0]  mem [DMEM_BYTES];
  logic [7:0]  rdata_r;
  logic [2:0]  bi_r, nbytes;
  logic        wr_r, take_r;
  logic [2:0]  st_r;
  logic [5:0]  alu_op;
  logic [31:0] alu_a, alu_b, alu_y, ldv;
  logic        alu_take;
  logic [31:0] res_r;
  div_ctl_t    dctl;
  div_sts_t    dsts;
  logic [31:0] dres;
  logic [AW-1:0] maddr;
  logic        is_store, is_load;

  // Sign-magnitude 12-bit immediate.
  always_comb begin
    logic [31:0] mg;
    mg = 32'd0 - v_r;
    imm = v_r[31] ? (32'd0 - {20'd0, mg[11:0]}) : {20'd0, v_r[11:0]};
  end
  assign is_load  = cmd_r >= OP_LB && cmd_r <= OP_LHU;
  assign is_store = cmd_r >= OP_SB && cmd_r <= OP_SW;
  always_comb begin
    case (cmd_r)
      OP_LB, OP_LBU, OP_SB: nbytes = 3'd1;
      OP_LH, OP_LHU, OP_SH: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
  end

  // ALU operand selection; branch target pass reuses the adder.
  always_comb begin
    alu_op = cmd_r; alu_a = a_r; alu_b = imm;
    case (cmd_r)
      OP_LUI: begin alu_a = 32'd0; alu_b = v_r << 12; end
      OP_AUIPC: begin alu_a = pc_r; alu_b = v_r << 12; end
      OP_SLTIU: alu_b = {20'd0, v_r[11:0]};
      OP_SLLI, OP_SRLI, OP_SRAI: alu_b = {27'd0, v_r[4:0]};
      OP_JAL: begin alu_op = OP_ADD; alu_a = pc_r; end
      default: begin
        if ((cmd_r >= OP_ADD && cmd_r <= OP_SRA) || (cmd_r >= OP_MUL && cmd_r <= OP_MULHU))
          alu_b = b_r;
        if (cmd_r >= OP_BEQ && cmd_r <= OP_BGEU) begin
          alu_a = d_r; alu_b = a_r;
        end
        if (is_load || is_store || cmd_r == OP_JALR) alu_op = OP_ADD;
      end
    endcase
    if (state_r == S_BR) begin
      alu_op = OP_ADD; alu_a = pc_r; alu_b = imm;
    end
  end

  rvx_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y), .take(alu_take));

  assign dctl.start = (state_r == S_EXEC) && cmd_r >= OP_DIV && cmd_r <= OP_REMU;
  assign dctl.signed_op = cmd_r == OP_DIV || cmd_r == OP_REM;
  assign dctl.want_rem = cmd_r == OP_REM || cmd_r == OP_REMU;
  rvx_div u_div (.clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(a_r), .divisor(b_r),
                 .sts(dsts), .result(dres));

  assign maddr = AW'(addr_r + {29'd0, bi_r});
  // Byte port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state_r == S_MEM && is_store) mem[maddr] <= d_r[8*bi_r +: 8];
    rdata_r <= mem[maddr];
  end
  always_comb begin
    ldv = acc_r;
    if (cmd_r == OP_LB) ldv = {{24{acc_r[7]}}, acc_r[7:0]};
    if (cmd_r == OP_LH) ldv = {{16{acc_r[15]}}, acc_r[15:0]};
  end

  always_comb begin
    state_nxt = state_r; pc_nxt = pc_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_READ;
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        if (cmd_r >= OP_DIV && cmd_r <= OP_REMU) state_nxt = S_DIV;
        else if (cmd_r >= OP_BEQ && cmd_r <= OP_BGEU) state_nxt = S_BR;
        else if (is_load || is_store) state_nxt = S_MEM;
        else state_nxt = S_DONE;
      end
      S_BR: state_nxt = S_DONE;
      S_MEM: state_nxt = is_store ? ((bi_r == nbytes - 3'd1) ? S_DONE : S_MEM) : S_MWAIT;
      S_MWAIT: state_nxt = (bi_r == nbytes - 3'd1) ? S_DONE : S_MEM;
      S_DIV: if (dsts.done) state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pc_r <= 32'd0;
      for (int i = 0; i < 32; i++) regs_r[i] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_cmd; rd_r <= in_first_reg; rs_r <= in_second_reg;
          v_r <= in_operand_value;
        end
        S_READ: begin
          a_r <= regs_r[rs_r]; b_r <= regs_r[v_r[4:0]]; d_r <= regs_r[rd_r];
          wr_r <= 1'b0; st_r <= ST_OK; take_r <= 1'b0; res_r <= 32'd0;
          bi_r <= 3'd0; acc_r <= 32'd0; addr_r <= pc_r + 32'd4;
        end
        S_EXEC: begin
          // Memory address, jump target, or the fall-through PC.
          addr_r <= (is_load || is_store || cmd_r == OP_JAL ||
                     (cmd_r == OP_JALR && alu_y != 32'd0 && !alu_y[31])) ?
                    alu_y : pc_r + 32'd4;
          if (cmd_r <= OP_SRA || (cmd_r >= OP_MUL && cmd_r <= OP_MULHU)) begin
            res_r <= alu_y; wr_r <= 1'b1;
          end
          if (cmd_r == OP_ECALL) st_r <= ST_ECALL;
          if (cmd_r == OP_EBREAK) st_r <= ST_EBREAK;
          if (cmd_r == OP_JAL) begin
            res_r <= pc_r + 32'd4; wr_r <= 1'b1; take_r <= 1'b1;
          end
          if (cmd_r == OP_JALR) begin
            if (alu_y == 32'd0) st_r <= ST_EXIT;
            else if (alu_y[31]) st_r <= ST_NEG;
            else begin
              res_r <= pc_r + 32'd4; wr_r <= 1'b1; take_r <= 1'b1;
            end
          end
          if (cmd_r >= OP_BEQ && cmd_r <= OP_BGEU) take_r <= alu_take;
        end
        S_BR: addr_r <= take_r ? alu_y : pc_r + 32'd4;
        S_MEM: if (is_store) bi_r <= bi_r + 3'd1;
        S_MWAIT: begin
          acc_r <= acc_r | ({24'd0, rdata_r} << (8 * bi_r));
          bi_r <= bi_r + 3'd1;
          if (bi_r == nbytes - 3'd1) wr_r <= 1'b1;
        end
        S_DIV: if (dsts.done) begin
          res_r <= dres; wr_r <= 1'b1;
        end
        S_DONE: begin
          if (is_load || is_store) addr_r <= pc_r + 32'd4;
          if (wr_r && rd_r != 5'd0) begin
            regs_r[rd_r] <= is_load ? ldv : res_r;
            if (is_load) res_r <= ldv;
          end else begin
            wr_r <= 1'b0; res_r <= 32'd0;
          end
          if (!is_load && !is_store) pc_r <= addr_r;
          else pc_r <= pc_r + 32'd4;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_status = st_r;
  assign out_next_pc = pc_r;
  assign out_dest_written = wr_r;
  assign out_dest_value = res_r;

  `RVX_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready, "accept while result pending")
  `RVX_ASSERT_IMP(a_nowr, clk, rst_n, out_valid && !out_dest_written, out_dest_value == 32'd0,
    "unwritten result not zero")
  `RVX_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_next_pc),
    "result dropped while stalled")
endmodule
`default_nettype wire

// File: src/rvx_div.sv
// ----------------------------------------------------------------------------
// rvx_div
// Radix-2 restoring divider, one quotient bit per cycle, with RISC-V fixups.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rvx_pkg::div_ctl_t ctl,
  input  wire logic [31:0]      dividend,
  input  wire logic [31:0]      divisor,
  output rvx_pkg::div_sts_t     sts,
  output logic [31:0]           result
);
  import rvx_pkg::*;
  logic [31:0] q_r, q_nxt, den_r, den_nxt, res_r, res_nxt;
  logic [32:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic        nq_r, nq_nxt, nr_r, nr_nxt, rm_r, rm_nxt;
  logic        na, nb;
  logic [31:0] ma, mb;
  assign na = ctl.signed_op & dividend[31];
  assign nb = ctl.signed_op & divisor[31];
  assign ma = na ? (32'd0 - dividend) : dividend;
  assign mb = nb ? (32'd0 - divisor) : divisor;
  assign trial = {rem_r[31:0], q_r[31]} - {1'b0, den_r};
  always_comb begin
    q_nxt = q_r; den_nxt = den_r; rem_nxt = rem_r; cnt_nxt = cnt_r; res_nxt = res_r;
    busy_nxt = busy_r; done_nxt = 1'b0; nq_nxt = nq_r; nr_nxt = nr_r; rm_nxt = rm_r;
    if (ctl.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd32; q_nxt = ma; den_nxt = mb; rem_nxt = 33'd0;
      nq_nxt = na ^ nb; nr_nxt = na; rm_nxt = ctl.want_rem;
      // Zero divisor: magnitude path gives all ones and the dividend magnitude, so
      // clear the quotient sign fixup and keep the dividend's sign on the remainder.
      if (divisor == 32'd0) begin
        nq_nxt = 1'b0; nr_nxt = na;
      end
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        if (rm_r) res_nxt = nr_r ? (32'd0 - rem_nxt[31:0]) : rem_nxt[31:0];
        else res_nxt = nq_r ? (32'd0 - q_nxt) : q_nxt;
      end
    end
  end
  always_ff @(posedge clk) begin
    q_r <= q_nxt; den_r <= den_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; res_r <= res_nxt;
    nq_r <= nq_nxt; nr_r <= nr_nxt; rm_r <= rm_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end
  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result = res_r;
endmodule
`default_nettype wire

// File: src/rvx_alu.sv
// ----------------------------------------------------------------------------
// rvx_alu
// Shared add, compare, logic, shift and multiply unit of the execute core.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_alu (
  input  wire logic [5:0]  op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      y,
  output logic             take
);
  import rvx_pkg::*;
  logic [63:0] prod;
  logic signed [32:0] sa, sb;
  logic        lts, ltu;
  logic [4:0]  sh;
  assign sh = b[4:0];
  assign lts = $signed(a) < $signed(b);
  assign ltu = a < b;
  always_comb begin
    sa = {(op == OP_MULH || op == OP_MULHSU) & a[31], a};
    sb = {(op == OP_MULH) & b[31], b};
  end
  assign prod = 64'(sa * sb);
  always_comb begin
    y = a + b;
    take = 1'b0;
    unique case (op)
      OP_SUB: y = a - b;
      OP_SLT, OP_SLTI: y = {31'd0, lts};
      OP_SLTU, OP_SLTIU: y = {31'd0, ltu};
      OP_XOR, OP_XORI: y = a ^ b;
      OP_OR, OP_ORI: y = a | b;
      OP_AND, OP_ANDI: y = a & b;
      OP_SLLI: y = a << sh;
      OP_SRL, OP_SRLI: y = a >> sh;
      OP_SRA, OP_SRAI: y = 32'($signed(a) >>> sh);
      OP_MUL: y = prod[31:0];
      OP_MULH, OP_MULHSU, OP_MULHU: y = prod[63:32];
      OP_BEQ: take = a == b;
      OP_BNE: take = a != b;
      OP_BLT: take = lts;
      OP_BGE: take = !lts;
      OP_BLTU: take = ltu;
      OP_BGEU: take = !ltu;
      default: y = a + b;
    endcase
  end
endmodule
`default_nettype wire
